@@ rtl/core/bfsa_pkg.sv @@
// Shared types and constants of the bitmap free-slot allocator.
package bfsa_pkg;

    // Request kinds.
    localparam logic KIND_FIND  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Slot 0 of a byte sits in its most significant bit.
    localparam logic [7:0] TOP_BIT    = 8'h80;
    localparam logic [7:0] EMPTY_BYTE = 8'h00;

    // Size register width and its value after reset.
    localparam int unsigned SIZE_W = 9;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_WR_RD,
        S_WR_MOD,
        S_HOLD
    } t_state;

    // Outcome of checking one map byte during a find.
    typedef struct packed {
        logic       hit;     // a free slot below the size lies in this byte
        logic       last;    // no slot in use lies beyond this byte
        logic [2:0] offset;  // position of the first free slot in the byte
    } t_scan_res;

endpackage

@@ rtl/core/bitmap_free_slot_allocator.sv @@
// Top level of the bitmap free-slot allocator: controller, map store and scanner.
//
// Usage: a request word (kind, bit_value, bit_index) enters on the input channel
// and exactly one result word (free_index, status) leaves on the output channel.
// A find walks the map store one byte per cycle from slot 0 and answers with the
// lowest free slot below the size in use (status ok) or status full. A write
// sets or clears one slot through a read-modify-write of its byte; an index at
// or beyond the size in use changes nothing and answers status range.
// One request is in work at a time. A find reads and checks the bytes in address
// order and stops at the first byte with a free slot or with no slot in use
// beyond it. A write reads its byte, then modifies and writes it back; an
// out-of-range write goes straight to its result. The single read port of the
// map store reads one byte per cycle. After reset the map store is cleared one
// byte per cycle, with no request taken; size writes are taken at any time.
// When the receiver stalls, the result stays in the output register and a
// second result waits in a holding register until the first one is taken.
module bitmap_free_slot_allocator #(
    parameter int unsigned MAP_BITS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic       i_bit_value,
    input  logic [7:0] i_bit_index,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_free_index,
    output logic [1:0] o_status,
    // Size register write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_size_in_use
);

    localparam int unsigned MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned LW = $clog2(MAP_BITS + 1);
    localparam int unsigned CW = (LW > bfsa_pkg::SIZE_W) ? LW : bfsa_pkg::SIZE_W;
    localparam int unsigned KW = (CW > AW + 4) ? CW : AW + 4;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

    bfsa_pkg::t_state r_state, n_state;

    logic [bfsa_pkg::SIZE_W-1:0] r_size;
    logic [AW-1:0]               r_addr, n_addr;
    logic                        r_chk_valid, n_chk_valid;
    logic [AW-1:0]               r_chk_addr, n_chk_addr;
    logic [2:0]                  r_bit_off, n_bit_off;
    logic                        r_bit_value, n_bit_value;
    logic [7:0]                  r_res_index, n_res_index;
    logic [1:0]                  r_res_status, n_res_status;
    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_index, n_out_index;
    logic [1:0]                  r_out_status, n_out_status;

    logic                        in_accept;
    logic                        out_free;
    logic [CW-1:0]               size_ext;
    logic [KW-1:0]               limit;
    logic [KW-1:0]               base;
    logic [KW-1:0]               found;
    logic [15:0]                 index_wide;
    logic [AW-1:0]               wr_byte;
    logic [7:0]                  bit_mask;
    logic                        mem_we;
    logic [7:0]                  mem_wdata;
    logic [7:0]                  mem_rdata;
    bfsa_pkg::t_scan_res         scan;

    // Handshakes.
    assign o_in_ready  = (r_state == bfsa_pkg::S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    // Size in use, capped at the map size.
    assign size_ext = CW'(r_size);
    assign limit    = (size_ext > CW'(MAP_BITS)) ? KW'(MAP_BITS) : KW'(size_ext);

    // Byte and bit of a written slot.
    assign index_wide = {8'h00, i_bit_index};
    assign wr_byte    = index_wide[AW+2:3];
    assign bit_mask   = bfsa_pkg::TOP_BIT >> r_bit_off;

    // First slot of the byte under check and the slot found in it.
    assign base  = KW'({r_chk_addr, 3'b000});
    assign found = base + KW'(scan.offset);

    bfsa_mem #(
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    bfsa_scan #(
        .KW (KW)
    ) u_scan (
        .i_byte  (mem_rdata),
        .i_base  (base),
        .i_limit (limit),
        .o_res   (scan)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfsa_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, store access and result capture.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_chk_valid  = r_chk_valid;
        n_chk_addr   = r_chk_addr;
        n_bit_off    = r_bit_off;
        n_bit_value  = r_bit_value;
        n_res_index  = r_res_index;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_index  = r_out_index;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_wdata    = bfsa_pkg::EMPTY_BYTE;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bfsa_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = bfsa_pkg::S_IDLE;
                end
            end
            bfsa_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_kind == bfsa_pkg::KIND_FIND) begin
                        n_addr      = '0;
                        n_chk_valid = 1'b0;
                        n_state     = bfsa_pkg::S_FIND;
                    end else if (KW'(i_bit_index) >= limit) begin
                        n_res_index  = 8'd0;
                        n_res_status = bfsa_pkg::ST_RANGE;
                        n_state      = bfsa_pkg::S_HOLD;
                    end else begin
                        n_addr      = wr_byte;
                        n_bit_off   = i_bit_index[2:0];
                        n_bit_value = i_bit_value;
                        n_state     = bfsa_pkg::S_WR_RD;
                    end
                end
            end
            bfsa_pkg::S_FIND: begin
                // Issue the next byte read while checking the byte read before.
                n_addr      = r_addr + 1'b1;
                n_chk_valid = 1'b1;
                n_chk_addr  = r_addr;
                if (r_chk_valid) begin
                    if (scan.hit) begin
                        n_res_index  = found[7:0];
                        n_res_status = bfsa_pkg::ST_OK;
                        n_chk_valid  = 1'b0;
                        n_state      = bfsa_pkg::S_HOLD;
                    end else if (scan.last) begin
                        n_res_index  = 8'd0;
                        n_res_status = bfsa_pkg::ST_FULL;
                        n_chk_valid  = 1'b0;
                        n_state      = bfsa_pkg::S_HOLD;
                    end
                end
            end
            bfsa_pkg::S_WR_RD: begin
                n_state = bfsa_pkg::S_WR_MOD;
            end
            bfsa_pkg::S_WR_MOD: begin
                mem_we       = 1'b1;
                mem_wdata    = r_bit_value ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
                n_res_index  = 8'd0;
                n_res_status = bfsa_pkg::ST_OK;
                n_state      = bfsa_pkg::S_HOLD;
            end
            bfsa_pkg::S_HOLD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_res_index;
                    n_out_status = r_res_status;
                    n_state      = bfsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfsa_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= bfsa_pkg::SIZE_RESET;
            r_addr      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_size_in_use;
            end
            r_addr      <= n_addr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_addr   <= n_chk_addr;
        r_bit_off    <= n_bit_off;
        r_bit_value  <= n_bit_value;
        r_res_index  <= n_res_index;
        r_res_status <= n_res_status;
        r_out_index  <= n_out_index;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_free_index = r_out_index;
    assign o_status     = r_out_status;

    // A request is taken only once the previous one has left the controller.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("request accepted while another is in work");

    // The map store is written only by the clearing pass and by a write request.
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == bfsa_pkg::S_CLEAR || r_state == bfsa_pkg::S_WR_MOD))
        else $error("map store written outside clear or modify");

    // A write at or beyond the size in use goes straight to the hold state with status range.
    a_range_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_kind == bfsa_pkg::KIND_WRITE && KW'(i_bit_index) >= limit)
        |=> (r_state == bfsa_pkg::S_HOLD && r_res_status == bfsa_pkg::ST_RANGE))
        else $error("out-of-range write not flagged");

    // Byte data is checked only while a find is running.
    a_check_in_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> (r_state == bfsa_pkg::S_FIND))
        else $error("byte check pending outside a find");

endmodule

@@ rtl/core/bfsa_mem.sv @@
// Byte-wide map storage with one write port and one registered read port.
module bfsa_mem #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bfsa_scan.sv @@
// Finds the first free slot in one map byte, bounded by the size in use.
module bfsa_scan #(
    parameter int unsigned KW = 10
) (
    input  logic [7:0]          i_byte,
    input  logic [KW-1:0]       i_base,
    input  logic [KW-1:0]       i_limit,
    output bfsa_pkg::t_scan_res o_res
);

    logic [KW-1:0] avail;
    logic [7:0]    free;

    // Slots of this byte that still lie below the size in use.
    assign avail = (i_limit > i_base) ? (i_limit - i_base) : '0;

    // A slot is free when its bit is clear and it is in use.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            free[j] = !i_byte[7-j] && (KW'(j) < avail);
        end
    end

    // Priority pick of the lowest free slot.
    always_comb begin
        o_res.hit    = |free;
        o_res.last   = (avail <= KW'(8));
        o_res.offset = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (free[j]) begin
                o_res.offset = 3'(j);
            end
        end
    end

endmodule
